>>> rtl/pcdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcdt_pkg;

    localparam int TABLE_ENTRIES_DEF = 20;
    localparam int MAX_BYTES_DEF     = 25;

    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int CHAN_W   = 7;
    localparam int IDX_W    = 5;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 5;
    localparam int RLEN_W   = 5;

    localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef enum logic [1:0] {
        K_BYTE  = 2'd0,
        K_END   = 2'd1,
        K_CLEAR = 2'd2,
        K_READ  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED     = 3'd0,
        ST_DUP        = 3'd1,
        ST_FULL       = 3'd2,
        ST_LONG       = 3'd3,
        ST_CLEARED    = 3'd4,
        ST_READ_OK    = 3'd5,
        ST_READ_EMPTY = 3'd6,
        ST_RSVD       = 3'd7
    } t_status;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [CHAN_W-1:0] channel;
        logic [IDX_W-1:0]  entry_index;
        logic [IDX_W-1:0]  byte_index;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [TOTAL_W-1:0] entry_total;
        logic [BYTE_W-1:0]  read_byte;
        logic [RLEN_W-1:0]  read_length;
        logic [CHAN_W-1:0]  read_channel;
    } t_res;

    function automatic int f_idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pcdt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pcdt_ram import pcdt_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [f_idx_w(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]            i_wdata,
    input  wire logic [f_idx_w(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/pcdt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pcdt_front import pcdt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic              i_last,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic [CHAN_W-1:0] i_channel,
    input  wire logic [IDX_W-1:0]  i_entry_index,
    input  wire logic [IDX_W-1:0]  i_byte_index,
    output logic                   o_cmd_valid,
    input  wire logic              i_cmd_ready,
    output t_cmd                   o_cmd
);

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_keep;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_keep = 1'b1;
        case (i_op)
            OP_BYTE:  w_cmd.kind = i_last ? K_END : K_BYTE;
            OP_CLEAR: w_cmd.kind = K_CLEAR;
            OP_READ:  w_cmd.kind = K_READ;
            default: begin
                w_cmd.kind = K_BYTE;
                w_keep     = 1'b0;
            end
        endcase
        w_cmd.data_byte   = i_data_byte;
        w_cmd.channel     = i_channel;
        w_cmd.entry_index = i_entry_index;
        w_cmd.byte_index  = i_byte_index;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready && w_keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

`default_nettype wire

>>> rtl/pcdt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pcdt_back import pcdt_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_BYTES     = MAX_BYTES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_ready,
    input  wire t_cmd i_cmd,
    output logic      o_res_valid,
    input  wire logic i_res_ready,
    output t_res      o_res
);

    localparam int CW   = $clog2(TABLE_ENTRIES + 1);
    localparam int EW   = f_idx_w(TABLE_ENTRIES);
    localparam int LW   = $clog2(MAX_BYTES + 1);
    localparam int BW   = f_idx_w(MAX_BYTES);
    localparam int DD   = TABLE_ENTRIES * MAX_BYTES;
    localparam int AW   = f_idx_w(DD);
    localparam int MW   = LW + CHAN_W;
    localparam int CMPW = 8;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_CHECK   = 9'b000000010,
        S_META    = 9'b000000100,
        S_CMP     = 9'b000001000,
        S_COPY_RD = 9'b000010000,
        S_COPY_WR = 9'b000100000,
        S_RD      = 9'b001000000,
        S_RD_DATA = 9'b010000000,
        S_EMIT    = 9'b100000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_stored, n_stored;
    logic [LW-1:0]   r_stg_count, n_stg_count;
    logic            r_ovf, n_ovf;
    t_cmd            r_cmd, n_cmd;
    logic [EW-1:0]   r_e, n_e;
    logic [AW-1:0]   r_base, n_base;
    logic [BW-1:0]   r_b, n_b;
    t_res            r_res, n_res;

    logic              w_stg_we;
    logic [BW-1:0]     w_stg_waddr;
    logic [BW-1:0]     w_stg_raddr;
    logic [BYTE_W-1:0] w_stg_rdata;
    logic              w_data_we;
    logic [AW-1:0]     w_data_waddr;
    logic [AW-1:0]     w_data_raddr;
    logic [BYTE_W-1:0] w_data_rdata;
    logic              w_meta_we;
    logic [EW-1:0]     w_meta_waddr;
    logic [MW-1:0]     w_meta_wdata;
    logic [EW-1:0]     w_meta_raddr;
    logic [MW-1:0]     w_meta_rdata;
    logic [LW-1:0]     w_meta_len;
    logic [CHAN_W-1:0] w_meta_chan;
    logic              w_last_entry;
    logic              w_last_byte;
    logic              w_bidx_ok;

    assign w_meta_len   = w_meta_rdata[LW-1:0];
    assign w_meta_chan  = w_meta_rdata[MW-1:LW];
    assign w_last_entry = ((CW'(r_e) + CW'(1)) == r_stored);
    assign w_last_byte  = ((LW'(r_b) + LW'(1)) == r_stg_count);
    assign w_bidx_ok    = (CMPW'(r_cmd.byte_index) < CMPW'(MAX_BYTES));

    pcdt_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_BYTES)) u_stg_ram (
        .i_clk   (i_clk),
        .i_we    (w_stg_we),
        .i_waddr (w_stg_waddr),
        .i_wdata (i_cmd.data_byte),
        .i_raddr (w_stg_raddr),
        .o_rdata (w_stg_rdata)
    );

    pcdt_ram #(.WIDTH(BYTE_W), .DEPTH(DD)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_data_we),
        .i_waddr (w_data_waddr),
        .i_wdata (w_stg_rdata),
        .i_raddr (w_data_raddr),
        .o_rdata (w_data_rdata)
    );

    pcdt_ram #(.WIDTH(MW), .DEPTH(TABLE_ENTRIES)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (w_meta_we),
        .i_waddr (w_meta_waddr),
        .i_wdata (w_meta_wdata),
        .i_raddr (w_meta_raddr),
        .o_rdata (w_meta_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_stored    = r_stored;
        n_stg_count = r_stg_count;
        n_ovf       = r_ovf;
        n_cmd       = r_cmd;
        n_e         = r_e;
        n_base      = r_base;
        n_b         = r_b;
        n_res       = r_res;

        w_stg_we     = 1'b0;
        w_stg_waddr  = r_stg_count[BW-1:0];
        w_data_we    = 1'b0;
        w_data_waddr = r_base + AW'(r_b);
        w_meta_we    = 1'b0;
        w_meta_waddr = r_stored[EW-1:0];
        w_meta_wdata = {r_cmd.channel, r_stg_count};
        o_cmd_ready  = 1'b0;
        o_res_valid  = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    n_res = '0;
                    case (i_cmd.kind)
                        K_BYTE, K_END: begin
                            if (r_stg_count < LW'(MAX_BYTES)) begin
                                w_stg_we    = 1'b1;
                                n_stg_count = r_stg_count + LW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                            if (i_cmd.kind == K_END) begin
                                n_state = S_CHECK;
                            end
                        end
                        K_CLEAR: begin
                            n_stored     = '0;
                            n_stg_count  = '0;
                            n_ovf        = 1'b0;
                            n_res.status = ST_CLEARED;
                            n_state      = S_EMIT;
                        end
                        K_READ: begin
                            n_state = S_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                n_e    = '0;
                n_b    = '0;
                n_base = '0;
                if (r_stored >= CW'(TABLE_ENTRIES)) begin
                    n_res.status = ST_FULL;
                    n_state      = S_EMIT;
                end else if (r_ovf) begin
                    n_res.status = ST_LONG;
                    n_state      = S_EMIT;
                end else if (r_stored == '0) begin
                    n_state = S_COPY_RD;
                end else begin
                    n_state = S_META;
                end
            end
            S_META: begin
                n_b = '0;
                if (w_meta_len == r_stg_count && w_meta_chan == r_cmd.channel) begin
                    n_state = S_CMP;
                end else begin
                    n_base = r_base + AW'(MAX_BYTES);
                    if (w_last_entry) begin
                        n_state = S_COPY_RD;
                    end else begin
                        n_e = r_e + EW'(1);
                    end
                end
            end
            S_CMP: begin
                if (w_data_rdata != w_stg_rdata) begin
                    n_b    = '0;
                    n_base = r_base + AW'(MAX_BYTES);
                    if (w_last_entry) begin
                        n_state = S_COPY_RD;
                    end else begin
                        n_e     = r_e + EW'(1);
                        n_state = S_META;
                    end
                end else if (w_last_byte) begin
                    n_res.status = ST_DUP;
                    n_state      = S_EMIT;
                end else begin
                    n_b = r_b + BW'(1);
                end
            end
            S_COPY_RD: begin
                n_state = S_COPY_WR;
            end
            S_COPY_WR: begin
                w_data_we = 1'b1;
                if (w_last_byte) begin
                    w_meta_we    = 1'b1;
                    n_stored     = r_stored + CW'(1);
                    n_res.status = ST_STORED;
                    n_state      = S_EMIT;
                end else begin
                    n_b     = r_b + BW'(1);
                    n_state = S_COPY_RD;
                end
            end
            S_RD: begin
                if (CMPW'(r_cmd.entry_index) >= CMPW'(r_stored)) begin
                    n_res.status = ST_READ_EMPTY;
                    n_state      = S_EMIT;
                end else begin
                    n_state = S_RD_DATA;
                end
            end
            S_RD_DATA: begin
                n_res.status       = ST_READ_OK;
                n_res.read_length  = RLEN_W'(w_meta_len);
                n_res.read_channel = w_meta_chan;
                if (w_bidx_ok && CMPW'(r_cmd.byte_index) < CMPW'(w_meta_len)) begin
                    n_res.read_byte = w_data_rdata;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    if (r_cmd.kind == K_END) begin
                        n_stg_count = '0;
                        n_ovf       = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (r_state == S_RD) begin
            w_meta_raddr = EW'(r_cmd.entry_index);
            w_data_raddr = AW'(EW'(r_cmd.entry_index)) * AW'(MAX_BYTES)
                         + (w_bidx_ok ? AW'(r_cmd.byte_index) : AW'(0));
            w_stg_raddr  = n_b;
        end else begin
            w_meta_raddr = n_e;
            w_data_raddr = n_base + AW'(n_b);
            w_stg_raddr  = n_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_e    <= n_e;
        r_base <= n_base;
        r_b    <= n_b;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stored    <= '0;
            r_stg_count <= '0;
            r_ovf       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stored    <= n_stored;
            r_stg_count <= n_stg_count;
            r_ovf       <= n_ovf;
        end
    end

    always_comb begin
        o_res             = r_res;
        o_res.entry_total = TOTAL_W'(r_stored);
    end

    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= CW'(TABLE_ENTRIES))
        else $error("stored count beyond table size");

    a_stg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg_count <= LW'(MAX_BYTES))
        else $error("staging count beyond max bytes");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_META || r_state == S_CMP) |-> (CW'(r_e) < r_stored))
        else $error("scan index past stored entries");

    a_clear_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_CLEARED) |-> (o_res.entry_total == '0))
        else $error("clear result with nonzero total");

    a_end_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_cmd_valid && i_cmd.kind == K_END)
        |=> (r_stg_count != '0))
        else $error("packet end with empty staging");

endmodule

`default_nettype wire

>>> rtl/packet_capture_dedup_table.sv
// Packet capture table that keeps only distinct packets.
// Slave stream: one word per operation. tuser carries the op (byte, clear,
// read), tlast marks the last byte of a packet. Op code 3 is taken and dropped.
// Master stream: one word per packet end, clear or read; none for other bytes.
// A two-word queue sits behind the slave side, so words are taken while a
// result waits on the master side; a full queue drops s_axis_tready.
// A non-final byte goes straight into staging. A read fetches the entry's length,
// channel and one data byte. A packet end scans the stored entries in order,
// matching length and channel and then each byte, and appends the packet from
// staging if none matches; bytes are compared on the single data RAM read port.
// The master output register is held while m_axis_tready is low; the engine
// then waits with its result and the queue fills.
// Reset (synchronous, i_rst_n low) empties the table, staging and queue; the
// RAMs keep their contents and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module packet_capture_dedup_table import pcdt_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_BYTES     = MAX_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // data_byte[7:0], channel[14:8], entry_index[19:15], byte_index[24:20], zero[31:25]
    input  wire logic [31:0] s_axis_tdata,
    // op[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // entry_total[4:0], read_byte[12:5], read_length[17:13], read_channel[24:18], zero[31:25]
    output logic [31:0]      m_axis_tdata,
    // status[2:0]
    output logic [2:0]       m_axis_tuser
);

    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;
    logic w_res_valid;
    logic w_res_ready;
    t_res w_res;
    logic r_out_valid;
    t_res r_out;

    pcdt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_op          (s_axis_tuser),
        .i_last        (s_axis_tlast),
        .i_data_byte   (s_axis_tdata[7:0]),
        .i_channel     (s_axis_tdata[14:8]),
        .i_entry_index (s_axis_tdata[19:15]),
        .i_byte_index  (s_axis_tdata[24:20]),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_ready   (w_cmd_ready),
        .o_cmd         (w_cmd)
    );

    pcdt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_BYTES     (MAX_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {7'd0, r_out.read_channel, r_out.read_length,
                            r_out.read_byte, r_out.entry_total};

endmodule

`default_nettype wire
